// File: design/mcke_pkg.sv
package mcke_pkg;

	// segment kinds
	localparam logic [2:0] KIND_DIT         = 3'd0;
	localparam logic [2:0] KIND_DAH         = 3'd1;
	localparam logic [2:0] KIND_ELEMENT_GAP = 3'd2;
	localparam logic [2:0] KIND_LETTER_GAP  = 3'd3;
	localparam logic [2:0] KIND_WORD_GAP    = 3'd4;

	// register indexes (byte address 4*i)
	localparam logic [2:0] REG_DIT   = 3'd0;
	localparam logic [2:0] REG_DAH   = 3'd1;
	localparam logic [2:0] REG_EGAP  = 3'd2;
	localparam logic [2:0] REG_LGAP  = 3'd3;
	localparam logic [2:0] REG_WGAP  = 3'd4;

	localparam logic [15:0] RST_DIT  = 16'd480;
	localparam logic [15:0] RST_DAH  = 16'd1440;
	localparam logic [15:0] RST_EGAP = 16'd480;
	localparam logic [15:0] RST_LGAP = 16'd1440;
	localparam logic [15:0] RST_WGAP = 16'd2400;

	localparam int ADDR_W = 5;
	localparam int MAX_ELEM = 6;

	// code meaning space or newline
	localparam logic [6:0] CODE_WORD = 7'd1;

	typedef struct packed {
		logic       load;   // capture the incoming word
		logic       emit;   // write a segment into the output register
		logic [2:0] kind;
		logic       last;
		logic       shift;  // advance to the next element
	} mcke_cmd_t;

	typedef struct packed {
		logic lgap_pend;  // letter gap owed before this character
		logic is_word;
		logic is_known;   // code with at least one element
		logic cur_dah;
		logic last_elem;
		logic out_free;
	} mcke_sts_t;

	// Morse code: leading 1 then elements (1 = dah); 0 = not in table
	function automatic logic [6:0] morse_code(input logic [7:0] ch_in);
		logic [7:0] ch;
		logic [6:0] c;
		ch = ch_in;
		if (ch >= 8'h41 && ch <= 8'h5A)
			ch = ch + 8'h20;
		case (ch)
			8'h0A, 8'h20: c = CODE_WORD;
			8'h65: c = 7'd2;   8'h74: c = 7'd3;   8'h69: c = 7'd4;
			8'h61: c = 7'd5;   8'h6E: c = 7'd6;   8'h6D: c = 7'd7;
			8'h73: c = 7'd8;   8'h75: c = 7'd9;   8'h72: c = 7'd10;
			8'h77: c = 7'd11;  8'h64: c = 7'd12;  8'h6B: c = 7'd13;
			8'h67: c = 7'd14;  8'h6F: c = 7'd15;  8'h68: c = 7'd16;
			8'h76: c = 7'd17;  8'h66: c = 7'd18;  8'h6C: c = 7'd20;
			8'h70: c = 7'd22;  8'h6A: c = 7'd23;  8'h62: c = 7'd24;
			8'h78: c = 7'd25;  8'h63: c = 7'd26;  8'h79: c = 7'd27;
			8'h7A: c = 7'd28;  8'h71: c = 7'd29;
			8'h35: c = 7'd32;  8'h34: c = 7'd33;  8'h33: c = 7'd35;
			8'h32: c = 7'd39;  8'h26: c = 7'd40;  8'h2B: c = 7'd42;
			8'h31: c = 7'd47;  8'h36: c = 7'd48;  8'h3D: c = 7'd49;
			8'h2F: c = 7'd50;  8'h28: c = 7'd54;  8'h37: c = 7'd56;
			8'h38: c = 7'd60;  8'h39: c = 7'd62;  8'h30: c = 7'd63;
			8'h3F: c = 7'd76;  8'h22: c = 7'd82;  8'h2E: c = 7'd85;
			8'h40: c = 7'd90;  8'h27: c = 7'd94;  8'h2D: c = 7'd97;
			8'h29: c = 7'd109; 8'h2C: c = 7'd115; 8'h3A: c = 7'd120;
			default: c = 7'd0;
		endcase
		return c;
	endfunction

endpackage

// File: design/mcke_ctrl.sv
module mcke_ctrl import mcke_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  mcke_sts_t sts,
	output mcke_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SEL  = 3'd1;
	localparam logic [2:0] S_LGAP = 3'd2;
	localparam logic [2:0] S_WORD = 3'd3;
	localparam logic [2:0] S_ELEM = 3'd4;
	localparam logic [2:0] S_EGAP = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [2:0] after_lgap;

	assign in_stall = (state_q != S_IDLE);

	// what follows the letter gap (or the select step with no gap owed)
	always_comb begin
		if (sts.is_word)
			after_lgap = S_WORD;
		else if (sts.is_known)
			after_lgap = S_ELEM;
		else
			after_lgap = S_IDLE;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.kind  = KIND_DIT;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SEL;
				end
			end
			S_SEL: begin
				state_d = sts.lgap_pend ? S_LGAP : after_lgap;
			end
			S_LGAP: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_LETTER_GAP;
					cmd.last = !(sts.is_word || sts.is_known);
					state_d  = after_lgap;
				end
			end
			S_WORD: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_WORD_GAP;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_ELEM: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					cmd.kind  = sts.cur_dah ? KIND_DAH : KIND_DIT;
					cmd.last  = sts.last_elem;
					cmd.shift = 1'b1;
					state_d   = sts.last_elem ? S_IDLE : S_EGAP;
				end
			end
			S_EGAP: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_ELEMENT_GAP;
					state_d  = S_ELEM;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// File: design/mcke_dp.sv
module mcke_dp import mcke_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	input  logic              pready,
	input  logic [7:0]        char_code,
	input  mcke_cmd_t         cmd,
	output mcke_sts_t         sts,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        segment_kind,
	output logic              tone_on,
	output logic [15:0]       duration,
	output logic              last_segment
);

	logic [15:0] dit_q, dah_q, egap_q, lgap_q, wgap_q;
	logic [2:0]  reg_idx;
	logic        wr_en;

	logic        seen_q;
	logic        lgap_pend_q;
	logic        word_q;
	logic        known_q;
	logic [MAX_ELEM-1:0] elem_q;
	logic [2:0]  cnt_q;

	logic [6:0]  code;
	logic [2:0]  top;
	logic [MAX_ELEM-1:0] elem_d;
	logic [15:0] dur_sel;

	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dit_q  <= RST_DIT;
			dah_q  <= RST_DAH;
			egap_q <= RST_EGAP;
			lgap_q <= RST_LGAP;
			wgap_q <= RST_WGAP;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DIT:  dit_q  <= pwdata[15:0];
				REG_DAH:  dah_q  <= pwdata[15:0];
				REG_EGAP: egap_q <= pwdata[15:0];
				REG_LGAP: lgap_q <= pwdata[15:0];
				REG_WGAP: wgap_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DIT:  prdata = {16'd0, dit_q};
			REG_DAH:  prdata = {16'd0, dah_q};
			REG_EGAP: prdata = {16'd0, egap_q};
			REG_LGAP: prdata = {16'd0, lgap_q};
			REG_WGAP: prdata = {16'd0, wgap_q};
			default:  prdata = 32'd0;
		endcase
	end

	// decode: element count is the position of the leading 1
	assign code = morse_code(char_code);

	always_comb begin
		if (code[6])      top = 3'd6;
		else if (code[5]) top = 3'd5;
		else if (code[4]) top = 3'd4;
		else if (code[3]) top = 3'd3;
		else if (code[2]) top = 3'd2;
		else if (code[1]) top = 3'd1;
		else              top = 3'd0;
	end

	// elements left-aligned so the first one sits in the top bit
	always_comb begin
		case (top)
			3'd6:    elem_d = code[5:0];
			3'd5:    elem_d = {code[4:0], 1'b0};
			3'd4:    elem_d = {code[3:0], 2'b0};
			3'd3:    elem_d = {code[2:0], 3'b0};
			3'd2:    elem_d = {code[1:0], 4'b0};
			3'd1:    elem_d = {code[0], 5'b0};
			default: elem_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			lgap_pend_q <= 1'b0;
			word_q      <= 1'b0;
			known_q     <= 1'b0;
			cnt_q       <= 3'd0;
		end else if (cmd.load) begin
			seen_q      <= 1'b1;
			lgap_pend_q <= seen_q;
			word_q      <= (code == CODE_WORD);
			known_q     <= (top != 3'd0);
			cnt_q       <= top;
		end else if (cmd.shift) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			elem_q <= elem_d;
		else if (cmd.shift)
			elem_q <= {elem_q[MAX_ELEM-2:0], 1'b0};
	end

	assign sts.lgap_pend = lgap_pend_q;
	assign sts.is_word   = word_q;
	assign sts.is_known  = known_q;
	assign sts.cur_dah   = elem_q[MAX_ELEM-1];
	assign sts.last_elem = (cnt_q == 3'd1);
	assign sts.out_free  = !out_valid || !out_stall;

	always_comb begin
		case (cmd.kind)
			KIND_DIT:         dur_sel = dit_q;
			KIND_DAH:         dur_sel = dah_q;
			KIND_ELEMENT_GAP: dur_sel = egap_q;
			KIND_LETTER_GAP:  dur_sel = lgap_q;
			KIND_WORD_GAP:    dur_sel = wgap_q;
			default:          dur_sel = 16'd0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd.emit)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			segment_kind <= cmd.kind;
			tone_on      <= (cmd.kind == KIND_DIT) || (cmd.kind == KIND_DAH);
			duration     <= dur_sel;
			last_segment <= cmd.last;
		end
	end

endmodule

// File: design/morse_code_keying_encoder.sv
// Morse keying encoder: each input word is one text byte; the block answers
// with the keying segments for it, one output word per segment (kind, tone_on,
// duration in samples, last_segment on the final one). Every byte after the
// first, known or not, is preceded by a letter gap; space and newline give a
// word gap; table characters (letters case-insensitive) give their dits and
// dahs with element gaps between; other bytes give nothing of their own, so
// an unknown first byte gives no output word. Durations come from five 16-bit
// registers on the APB port (dit, dah, element gap, letter gap, word gap at
// byte addresses 0x00..0x10); the user must write them only while the block
// is idle, as the block itself does not enforce this. One byte is handled at
// a time by the control state machine: the idle state takes the byte, the
// select state picks the first segment, then one segment per cycle leaves
// into the output register while that register is free. The next byte is
// taken while the last segment still sits in the output register.
module morse_code_keying_encoder import mcke_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        char_code,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        segment_kind,
	output logic              tone_on,
	output logic [15:0]       duration,
	output logic              last_segment
);

	mcke_cmd_t cmd;
	mcke_sts_t sts;

	assign pready = 1'b1;

	mcke_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mcke_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.char_code    (char_code),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.segment_kind (segment_kind),
		.tone_on      (tone_on),
		.duration     (duration),
		.last_segment (last_segment)
	);

endmodule

// File: design/mcke_chk.sv
module mcke_chk import mcke_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  segment_kind,
	input logic        tone_on,
	input logic [15:0] duration,
	input logic        last_segment
);

	// one byte at a time: busy right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while previous byte in progress");

	a_tone_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tone_on == ((segment_kind == KIND_DIT) ||
			(segment_kind == KIND_DAH))))
		else $error("tone_on disagrees with segment kind");

	// word gap always ends a byte; element gap never does
	a_last_marks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (((segment_kind == KIND_WORD_GAP) && last_segment) ||
			((segment_kind == KIND_ELEMENT_GAP) && !last_segment) ||
			(segment_kind == KIND_DIT) || (segment_kind == KIND_DAH) ||
			(segment_kind == KIND_LETTER_GAP)))
		else $error("bad last_segment marking");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(segment_kind) &&
			$stable(duration) && $stable(last_segment)))
		else $error("stalled output word changed");

endmodule

bind morse_code_keying_encoder mcke_chk u_mcke_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.segment_kind (segment_kind),
	.tone_on      (tone_on),
	.duration     (duration),
	.last_segment (last_segment)
);

// File: tb/morse_code_keying_encoder_tb.sv
// Stimulus runs on the rising edge with nonblocking drives. The checker samples
// the pre-edge values at the same edge, so no race is possible with the block.
module morse_code_keying_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mcke_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES   = 300;  // long output hold-off
	localparam int PRINT_CAP     = 100;

	// no register lives at this index; a write there must change nothing
	localparam logic [2:0] REG_UNMAPPED = 3'd6;

	// one keying segment as it leaves the block
	typedef struct {
		logic [2:0]  kind;
		logic        tone;
		logic [15:0] dur;
		logic        last;
	} keying_seg_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        char_code = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [2:0]        segment_kind;
	logic              tone_on;
	logic [15:0]       duration;
	logic              last_segment;

	// local copy of the duration registers and of the first-byte flag
	logic [15:0] dit_len  = RST_DIT;
	logic [15:0] dah_len  = RST_DAH;
	logic [15:0] egap_len = RST_EGAP;
	logic [15:0] lgap_len = RST_LGAP;
	logic [15:0] wgap_len = RST_WGAP;
	logic        char_seen = 1'b0;

	// segments predicted but not yet seen, oldest first
	keying_seg_t segs_due[$];

	int  mismatches = 0;
	int  cycles = 0;
	bit  stall_on = 1'b0;   // random output stalls enabled
	bit  gaps_on = 1'b0;    // random input gaps enabled
	int  hold_seq = 0;      // bumped by a test to ask for a long hold-off
	int  hold_ack = 0;
	int  stall_left = 0;

	// every character of the Morse table except space and newline
	string table_chars = "abcdefghijklmnopqrstuvwxyz0123456789&+=/()?\".@'-,:";

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	morse_code_keying_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.segment_kind (segment_kind),
		.tone_on      (tone_on),
		.duration     (duration),
		.last_segment (last_segment)
	);

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// dot/dash spelling of a lowercase table character, empty if not in the table
	function automatic string morse_pattern(input logic [7:0] ch);
		case (ch)
			"a": return ".-";     "b": return "-...";   "c": return "-.-.";
			"d": return "-..";    "e": return ".";      "f": return "..-.";
			"g": return "--.";    "h": return "....";   "i": return "..";
			"j": return ".---";   "k": return "-.-";    "l": return ".-..";
			"m": return "--";     "n": return "-.";     "o": return "---";
			"p": return ".--.";   "q": return "--.-";   "r": return ".-.";
			"s": return "...";    "t": return "-";      "u": return "..-";
			"v": return "...-";   "w": return ".--";    "x": return "-..-";
			"y": return "-.--";   "z": return "--..";
			"0": return "-----";  "1": return ".----";  "2": return "..---";
			"3": return "...--";  "4": return "....-";  "5": return ".....";
			"6": return "-....";  "7": return "--...";  "8": return "---..";
			"9": return "----.";
			"&": return ".-...";  "+": return ".-.-.";  "=": return "-...-";
			"/": return "-..-.";  "(": return "-.--.";  ")": return "-.--.-";
			"?": return "..--.."; ".": return ".-.-.-"; "@": return ".--.-.";
			"-": return "-....-"; ",": return "--..--"; ":": return "---...";
			8'h22: return ".-..-.";  // double quote
			8'h27: return ".----.";  // apostrophe
			default: return "";
		endcase
	endfunction

	function automatic void push_seg(input logic [2:0] kind, input logic [15:0] dur);
		keying_seg_t s;
		s.kind = kind;
		s.tone = (kind == KIND_DIT) || (kind == KIND_DAH);
		s.dur  = dur;
		s.last = 1'b0;
		segs_due.push_back(s);
	endfunction

	// Expected segments for one accepted byte. A letter gap comes before every
	// byte but the first, even an unknown one; an unknown first byte gives nothing.
	function automatic void predict_keying(input logic [7:0] ch);
		logic [7:0] lc;
		string      pat;
		int         n;
		int         i;
		n = 0;
		if (char_seen) begin
			push_seg(KIND_LETTER_GAP, lgap_len);
			n++;
		end
		char_seen = 1'b1;
		lc = (ch >= "A" && ch <= "Z") ? ch + 8'h20 : ch;
		if (lc == 8'h0A || lc == " ") begin
			push_seg(KIND_WORD_GAP, wgap_len);
			n++;
		end else begin
			pat = morse_pattern(lc);
			for (i = 0; i < pat.len(); i++) begin
				if (i > 0) begin
					push_seg(KIND_ELEMENT_GAP, egap_len);
					n++;
				end
				if (pat[i] == "-")
					push_seg(KIND_DAH, dah_len);
				else
					push_seg(KIND_DIT, dit_len);
				n++;
			end
		end
		if (n > 0)
			segs_due[segs_due.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("%0t ns mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// each output word is compared field by field with the oldest prediction
	always @(posedge clk) begin
		keying_seg_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (segs_due.size() == 0) begin
				report_mismatch($sformatf("unexpected word kind %0d duration %0d",
					segment_kind, duration));
			end else begin
				want = segs_due.pop_front();
				if (segment_kind !== want.kind)
					report_mismatch($sformatf("segment_kind got %0d want %0d",
						segment_kind, want.kind));
				if (tone_on !== want.tone)
					report_mismatch($sformatf("tone_on got %0d want %0d",
						tone_on, want.tone));
				if (duration !== want.dur)
					report_mismatch($sformatf("duration got %0d want %0d",
						duration, want.dur));
				if (last_segment !== want.last)
					report_mismatch($sformatf("last_segment got %0d want %0d",
						last_segment, want.last));
			end
		end
	end

	// ------------------------------------------------------------------
	// Output side: random stalls, plus the long hold-off on request
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_seq != hold_ack) begin
			hold_ack   <= hold_seq;
			stall_left <= HOLD_CYCLES - 1;
			out_stall  <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (stall_on && $urandom_range(0, 3) == 0) begin
			// now and then the stall becomes a long burst
			out_stall  <= 1'b1;
			stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
			                                           : $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Input side and register port
	// ------------------------------------------------------------------

	// Offer one byte and hold it until the block takes it. Valid stays high
	// into the next call when no gap is drawn.
	task automatic send_char(input logic [7:0] ch);
		int r;
		int gap;
		gap = 0;
		if (gaps_on) begin
			r = $urandom_range(0, 99);
			if (r >= 92)
				gap = $urandom_range(8, 40);
			else if (r >= 55)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= ch;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_keying(ch);
	endtask

	// stop offering, wait for every predicted word, then let the block settle
	// (an unknown byte can keep it busy with no word to show for it)
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (segs_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup cycle, then access cycle; upper data bits carry junk
	task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
		logic [15:0] junk;
		junk = 16'($urandom);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {junk, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_DIT:  dit_len  = val;
			REG_DAH:  dah_len  = val;
			REG_EGAP: egap_len = val;
			REG_LGAP: lgap_len = val;
			REG_WGAP: wgap_len = val;
			default: ;
		endcase
	endtask

	task automatic program_durations(input logic [15:0] dit, input logic [15:0] dah,
			input logic [15:0] egap, input logic [15:0] lgap, input logic [15:0] wgap);
		wait_idle();
		write_register(REG_DIT, dit);
		write_register(REG_DAH, dah);
		write_register(REG_EGAP, egap);
		write_register(REG_LGAP, lgap);
		write_register(REG_WGAP, wgap);
	endtask

	function automatic logic [15:0] random_length();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'd1;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom_range(1, 65535));
	endfunction

	// Mostly text the table knows, in either case, with spaces and newlines
	// mixed in; the rest is any byte at all.
	function automatic logic [7:0] pick_text_char();
		int         r;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			c = table_chars[$urandom_range(0, table_chars.len() - 1)];
			if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
				c = c - 8'h20;
		end else if (r < 85) begin
			c = ($urandom_range(0, 1) == 1) ? 8'h20 : 8'h0A;
		end else begin
			c = 8'($urandom_range(0, 255));
		end
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset durations. An unknown byte first (no word at all, but later bytes
	// get their letter gap), both cases of letters, the longest codes, space,
	// newline, and bytes outside the table at both ends of the range.
	task automatic test_directed_characters();
		send_char(8'h00);
		send_char("E");
		send_char("e");
		send_char("T");
		send_char(":");
		send_char("0");
		send_char(" ");
		send_char(8'h0A);
		send_char(8'h80);
		send_char(8'hFF);
		send_char(8'h7F);
		send_char("?");
		send_char("Q");
		send_char("5");
		send_char("@");
		send_char(")");
		send_char(",");
	endtask

	// Smallest, largest and zero durations; distinct values catch a swapped
	// register, and a write to an unmapped index must leave them alone.
	task automatic test_duration_extremes();
		program_durations(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		send_char("x");
		send_char(" ");
		program_durations(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_char("q");
		send_char(8'h0A);
		program_durations(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_char("b");
		send_char(" ");
		program_durations(16'd11, 16'd22, 16'd33, 16'd44, 16'd55);
		write_register(REG_UNMAPPED, 16'h1234);
		send_char("r");
		send_char(" ");
	endtask

	task automatic test_random_text(input int count, input bit idle_in, input bit idle_out);
		program_durations(random_length(), random_length(), random_length(),
			random_length(), random_length());
		gaps_on  = idle_in;
		stall_on = idle_out;
		repeat (count) send_char(pick_text_char());
	endtask

	// The output holds off for a long stretch while bytes keep coming with
	// no gaps, so the block fills and must stall its input.
	task automatic test_output_backpressure();
		program_durations(random_length(), random_length(), random_length(),
			random_length(), random_length());
		gaps_on  = 1'b0;
		stall_on = 1'b0;
		hold_seq = hold_seq + 1;
		repeat (30) send_char(pick_text_char());
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_characters();
		test_duration_extremes();
		test_random_text(70, 1'b0, 1'b0);
		test_random_text(80, 1'b1, 1'b1);
		test_random_text(60, 1'b1, 1'b0);
		test_output_backpressure();
		test_random_text(70, 1'b0, 1'b1);

		wait_idle();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: sim.f
design/mcke_pkg.sv
design/mcke_ctrl.sv
design/mcke_dp.sv
design/morse_code_keying_encoder.sv
design/mcke_chk.sv
tb/morse_code_keying_encoder_tb.sv
